// ----- rtl/core/sle_pkg.sv -----
package sle_pkg;

    localparam int MODE_W         = 2;
    localparam int POS_W          = 7;
    localparam int STATUS_W       = 2;
    localparam int FOUND_W        = 7;
    localparam int COUNT_W        = 7;
    localparam int DEPTH_DEF      = 128;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int M_DATA_W       = ((STATUS_W + FOUND_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_LOCATE  = 2'd2,
        MODE_REVERSE = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_BADPOS   = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOVE,
        ST_PUT,
        ST_SEARCH,
        ST_SWAP,
        ST_REPLY
    } state_t;

    typedef enum logic [1:0] {
        WALK_NONE,
        WALK_MOVE,
        WALK_SEARCH,
        WALK_SWAP
    } walk_t;

    typedef struct packed {
        logic  load;
        logic  setup;
        walk_t walk;
        logic  put;
        logic  emit;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  reject;
        logic  move_done;
        logic  search_done;
        logic  swap_done;
        logic  out_free;
    } ctrl_stat_t;

endpackage

// ----- rtl/core/sle_ctrl.sv -----
module sle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sle_pkg::ctrl_stat_t   stat,
    output sle_pkg::ctrl_cmd_t    cmd
);

    sle_pkg::state_t state_reg;
    sle_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sle_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sle_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sle_pkg::ST_CHECK;
                end
            end
            sle_pkg::ST_CHECK: begin
                case (stat.mode)
                    sle_pkg::MODE_INSERT,
                    sle_pkg::MODE_DELETE: begin
                        state_next = stat.reject ? sle_pkg::ST_REPLY : sle_pkg::ST_MOVE;
                    end
                    sle_pkg::MODE_LOCATE: begin
                        state_next = sle_pkg::ST_SEARCH;
                    end
                    default: begin
                        state_next = sle_pkg::ST_SWAP;
                    end
                endcase
            end
            sle_pkg::ST_MOVE: begin
                if (stat.move_done) begin
                    state_next = (stat.mode == sle_pkg::MODE_INSERT) ? sle_pkg::ST_PUT
                                                                     : sle_pkg::ST_REPLY;
                end
            end
            sle_pkg::ST_PUT: begin
                state_next = sle_pkg::ST_REPLY;
            end
            sle_pkg::ST_SEARCH: begin
                if (stat.search_done) begin
                    state_next = sle_pkg::ST_REPLY;
                end
            end
            sle_pkg::ST_SWAP: begin
                if (stat.swap_done) begin
                    state_next = sle_pkg::ST_REPLY;
                end
            end
            sle_pkg::ST_REPLY: begin
                if (stat.out_free) begin
                    state_next = sle_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd.load  = 1'b0;
        cmd.setup = 1'b0;
        cmd.walk  = sle_pkg::WALK_NONE;
        cmd.put   = 1'b0;
        cmd.emit  = 1'b0;
        case (state_reg)
            sle_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sle_pkg::ST_CHECK: begin
                cmd.setup = 1'b1;
            end
            sle_pkg::ST_MOVE: begin
                cmd.walk = sle_pkg::WALK_MOVE;
            end
            sle_pkg::ST_PUT: begin
                cmd.put = 1'b1;
            end
            sle_pkg::ST_SEARCH: begin
                cmd.walk = sle_pkg::WALK_SEARCH;
            end
            sle_pkg::ST_SWAP: begin
                cmd.walk = sle_pkg::WALK_SWAP;
            end
            sle_pkg::ST_REPLY: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/sle_dp.sv -----
module sle_dp #(
    parameter int DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  sle_pkg::ctrl_cmd_t           cmd,
    output sle_pkg::ctrl_stat_t          stat,
    input  sle_pkg::mode_t               in_mode,
    input  logic [sle_pkg::POS_W-1:0]    in_position,
    input  logic [ELEM_WIDTH-1:0]        in_value,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output sle_pkg::status_t             out_status,
    output logic [sle_pkg::FOUND_W-1:0]  out_found,
    output logic [sle_pkg::COUNT_W-1:0]  out_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    sle_pkg::mode_t            mode_reg,     mode_next;
    logic [sle_pkg::POS_W-1:0] pos_reg,      pos_next;
    logic [ELEM_WIDTH-1:0]     val_reg,      val_next;
    logic [CW-1:0]             cnt_reg,      cnt_next;
    logic [AW-1:0]             rd_lo_reg,    rd_lo_next;
    logic [AW-1:0]             rd_hi_reg,    rd_hi_next;
    logic [AW-1:0]             wr_lo_reg,    wr_lo_next;
    logic [AW-1:0]             wr_hi_reg,    wr_hi_next;
    logic [CW-1:0]             left_reg,     left_next;
    logic [CW-1:0]             step_reg,     step_next;
    logic                      pend_reg,     pend_next;
    logic [ELEM_WIDTH-1:0]     tmp_reg,      tmp_next;
    logic                      hit_reg,      hit_next;
    logic [AW-1:0]             hit_pos_reg,  hit_pos_next;
    logic                      m_valid_reg,  m_valid_next;
    sle_pkg::status_t          status_reg,   status_next;
    logic [sle_pkg::FOUND_W-1:0] found_reg,  found_next;
    logic [sle_pkg::COUNT_W-1:0] count_reg,  count_next;
    logic [ELEM_WIDTH-1:0]     rdata_reg;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ELEM_WIDTH-1:0] wr_data;
    logic [XW-1:0]         n_x;
    logic [XW-1:0]         pos_x;
    logic [CW-1:0]         two_p;
    logic                  full;
    logic                  ins_bad;
    logic                  del_bad;

    assign n_x     = XW'(cnt_reg);
    assign pos_x   = XW'(pos_reg);
    assign two_p   = left_reg << 1;
    assign full    = (cnt_reg >= CW'(DEPTH - 1));
    assign ins_bad = (pos_x == '0) || (pos_x > n_x + XW'(1));
    assign del_bad = (pos_x == '0) || (pos_x > n_x);

    always_comb begin
        stat.mode        = mode_reg;
        stat.reject      = 1'b0;
        case (mode_reg)
            sle_pkg::MODE_INSERT: stat.reject = full || ins_bad;
            sle_pkg::MODE_DELETE: stat.reject = del_bad;
            default:              stat.reject = 1'b0;
        endcase
        stat.move_done   = (left_reg == '0) && !pend_reg;
        stat.search_done = hit_reg || ((left_reg == '0) && !pend_reg);
        stat.swap_done   = (left_reg == '0) || (step_reg == two_p + CW'(1));
        stat.out_free    = !m_valid_reg || m_tready;
    end

    always_comb begin
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        rd_lo_next   = rd_lo_reg;
        rd_hi_next   = rd_hi_reg;
        wr_lo_next   = wr_lo_reg;
        wr_hi_next   = wr_hi_reg;
        left_next    = left_reg;
        step_next    = step_reg;
        pend_next    = pend_reg;
        tmp_next     = tmp_reg;
        hit_next     = hit_reg;
        hit_pos_next = hit_pos_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        rd_en        = 1'b0;
        rd_addr      = rd_lo_reg;
        wr_en        = 1'b0;
        wr_addr      = wr_lo_reg;
        wr_data      = rdata_reg;

        if (cmd.load) begin
            mode_next = in_mode;
            pos_next  = in_position;
            val_next  = in_value;
        end

        if (cmd.setup) begin
            pend_next = 1'b0;
            hit_next  = 1'b0;
            step_next = '0;
            case (mode_reg)
                sle_pkg::MODE_INSERT: begin
                    rd_lo_next = AW'(cnt_reg);
                    left_next  = CW'(n_x - pos_x + XW'(1));
                end
                sle_pkg::MODE_DELETE: begin
                    rd_lo_next = AW'(pos_x + XW'(1));
                    left_next  = CW'(n_x - pos_x);
                end
                sle_pkg::MODE_LOCATE: begin
                    rd_lo_next = AW'(1);
                    left_next  = cnt_reg;
                end
                default: begin
                    rd_lo_next = AW'(1);
                    rd_hi_next = AW'(cnt_reg);
                    wr_lo_next = AW'(1);
                    wr_hi_next = AW'(cnt_reg);
                    left_next  = cnt_reg >> 1;
                end
            endcase
        end

        case (cmd.walk)
            sle_pkg::WALK_MOVE: begin
                rd_en     = (left_reg != '0);
                rd_addr   = rd_lo_reg;
                wr_en     = pend_reg;
                wr_addr   = wr_lo_reg;
                wr_data   = rdata_reg;
                pend_next = rd_en;
                if (rd_en) begin
                    left_next = left_reg - CW'(1);
                    if (mode_reg == sle_pkg::MODE_INSERT) begin
                        rd_lo_next = rd_lo_reg - AW'(1);
                        wr_lo_next = rd_lo_reg + AW'(1);
                    end else begin
                        rd_lo_next = rd_lo_reg + AW'(1);
                        wr_lo_next = rd_lo_reg - AW'(1);
                    end
                end
            end
            sle_pkg::WALK_SEARCH: begin
                rd_en     = (left_reg != '0) && !hit_reg;
                rd_addr   = rd_lo_reg;
                pend_next = rd_en;
                if (rd_en) begin
                    left_next  = left_reg - CW'(1);
                    rd_lo_next = rd_lo_reg + AW'(1);
                    wr_lo_next = rd_lo_reg;
                end
                if (pend_reg && !hit_reg && (rdata_reg == val_reg)) begin
                    hit_next     = 1'b1;
                    hit_pos_next = wr_lo_reg;
                end
            end
            sle_pkg::WALK_SWAP: begin
                rd_en     = (step_reg < two_p);
                rd_addr   = step_reg[0] ? rd_hi_reg : rd_lo_reg;
                step_next = step_reg + CW'(1);
                if (rd_en && step_reg[0]) begin
                    rd_lo_next = rd_lo_reg + AW'(1);
                    rd_hi_next = rd_hi_reg - AW'(1);
                end
                if (step_reg[0]) begin
                    tmp_next = rdata_reg;
                end
                if (!step_reg[0] && (step_reg != '0)) begin
                    wr_en   = 1'b1;
                    wr_addr = wr_lo_reg;
                    wr_data = rdata_reg;
                end
                if (step_reg[0] && (step_reg != CW'(1))) begin
                    wr_en      = 1'b1;
                    wr_addr    = wr_hi_reg;
                    wr_data    = tmp_reg;
                    wr_lo_next = wr_lo_reg + AW'(1);
                    wr_hi_next = wr_hi_reg - AW'(1);
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase

        if (cmd.put) begin
            wr_en   = 1'b1;
            wr_addr = AW'(pos_reg);
            wr_data = val_reg;
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
            found_next   = '0;
            case (mode_reg)
                sle_pkg::MODE_INSERT: begin
                    if (full) begin
                        status_next = sle_pkg::STATUS_FULL;
                    end else if (ins_bad) begin
                        status_next = sle_pkg::STATUS_BADPOS;
                    end else begin
                        status_next = sle_pkg::STATUS_OK;
                        cnt_next    = cnt_reg + CW'(1);
                    end
                end
                sle_pkg::MODE_DELETE: begin
                    if (del_bad) begin
                        status_next = sle_pkg::STATUS_BADPOS;
                    end else begin
                        status_next = sle_pkg::STATUS_OK;
                        cnt_next    = cnt_reg - CW'(1);
                    end
                end
                sle_pkg::MODE_LOCATE: begin
                    if (hit_reg) begin
                        status_next = sle_pkg::STATUS_OK;
                        found_next  = sle_pkg::FOUND_W'(hit_pos_reg);
                    end else begin
                        status_next = sle_pkg::STATUS_NOTFOUND;
                    end
                end
                default: begin
                    status_next = sle_pkg::STATUS_OK;
                end
            endcase
            count_next = sle_pkg::COUNT_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg    <= mode_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        rd_lo_reg   <= rd_lo_next;
        rd_hi_reg   <= rd_hi_next;
        wr_lo_reg   <= wr_lo_next;
        wr_hi_reg   <= wr_hi_next;
        left_reg    <= left_next;
        step_reg    <= step_next;
        tmp_reg     <= tmp_next;
        hit_pos_reg <= hit_pos_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        count_reg   <= count_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign out_status = status_reg;
    assign out_found  = found_reg;
    assign out_count  = count_reg;

endmodule

// ----- rtl/core/sequential_list_engine_core.sv -----
// Each accepted word passes the check state, then the walk its mode needs (insert moves
// and then puts, delete moves, locate searches, reverse swaps), then the reply state; a
// rejected insert or delete goes from check straight to reply. One word is in flight at a
// time; the walk moves one list entry per cycle through the single-read, single-write list
// memory. A finished result may wait in the output register while the next word is
// accepted. aresetn (synchronous) empties the list and drops any result.
module sequential_list_engine_core #(
    parameter int  DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int  ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF,
    localparam int S_DATA_W   =
        ((sle_pkg::MODE_W + sle_pkg::POS_W + ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [S_DATA_W-1:0]          s_tdata,   // mode, position, value
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sle_pkg::M_DATA_W-1:0] m_tdata    // status, found_position, count
);

    localparam int POS_LSB = sle_pkg::MODE_W;
    localparam int VAL_LSB = sle_pkg::MODE_W + sle_pkg::POS_W;

    sle_pkg::ctrl_cmd_t          cmd;
    sle_pkg::ctrl_stat_t         stat;
    sle_pkg::status_t            out_status;
    logic [sle_pkg::FOUND_W-1:0] out_found;
    logic [sle_pkg::COUNT_W-1:0] out_count;

    sle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sle_dp #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (sle_pkg::mode_t'(s_tdata[sle_pkg::MODE_W-1:0])),
        .in_position (s_tdata[POS_LSB +: sle_pkg::POS_W]),
        .in_value    (s_tdata[VAL_LSB +: ELEM_WIDTH]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_status  (out_status),
        .out_found   (out_found),
        .out_count   (out_count)
    );

    assign m_tdata = sle_pkg::M_DATA_W'({out_count, out_found, out_status});

endmodule

// ----- rtl/core/sle_checker.sv -----
module sle_checker #(
    parameter int  DEPTH      = sle_pkg::DEPTH_DEF,
    parameter int  ELEM_WIDTH = sle_pkg::ELEM_WIDTH_DEF,
    localparam int S_DATA_W   =
        ((sle_pkg::MODE_W + sle_pkg::POS_W + ELEM_WIDTH + 7) / 8) * 8
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [S_DATA_W-1:0]          s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [sle_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int FOUND_LSB = sle_pkg::STATUS_W;
    localparam int COUNT_LSB = sle_pkg::STATUS_W + sle_pkg::FOUND_W;

    logic [sle_pkg::STATUS_W-1:0] st;
    logic [sle_pkg::FOUND_W-1:0]  found;
    logic [sle_pkg::COUNT_W-1:0]  cnt;

    assign st    = m_tdata[sle_pkg::STATUS_W-1:0];
    assign found = m_tdata[FOUND_LSB +: sle_pkg::FOUND_W];
    assign cnt   = m_tdata[COUNT_LSB +: sle_pkg::COUNT_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in flight");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (found != '0) |-> (st == sle_pkg::STATUS_OK))
        else $error("found position with a failing status");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st == sle_pkg::STATUS_FULL) |-> (cnt == sle_pkg::COUNT_W'(DEPTH - 1)))
        else $error("list full reported below capacity");

endmodule

bind sequential_list_engine_core sle_checker #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
) u_sle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/sequential_list_engine_core_tb.sv -----
module sequential_list_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = sle_pkg::DEPTH_DEF;
    localparam int ELEM_W      = sle_pkg::ELEM_WIDTH_DEF;
    localparam int S_W         = ((sle_pkg::MODE_W + sle_pkg::POS_W + ELEM_W + 7) / 8) * 8;
    localparam int RANDOM_WORDS = 850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 2 * LIST_DEPTH;

    typedef struct packed {
        sle_pkg::status_t            status;
        logic [sle_pkg::FOUND_W-1:0] found_pos;
        logic [sle_pkg::COUNT_W-1:0] count;
    } reply_t;

    class list_book;
        logic [ELEM_W-1:0] entries [LIST_DEPTH];
        int                n_entries;
        reply_t            replies_due [$];
        int                errors;

        function new();
            n_entries = 0;
            errors    = 0;
        endfunction

        function reply_t apply_request(sle_pkg::mode_t md, logic [sle_pkg::POS_W-1:0] pos,
                                       logic [ELEM_W-1:0] val);
            reply_t            r;
            int                n;
            int                p;
            int                j;
            bit                hit;
            logic [ELEM_W-1:0] t;
            r.status    = sle_pkg::STATUS_OK;
            r.found_pos = '0;
            n           = n_entries;
            p           = int'(pos);
            case (md)
                sle_pkg::MODE_INSERT: begin
                    if (n >= LIST_DEPTH - 1) begin
                        r.status = sle_pkg::STATUS_FULL;
                    end else if (p < 1 || p > n + 1) begin
                        r.status = sle_pkg::STATUS_BADPOS;
                    end else begin
                        for (j = n; j >= p; j--)
                            entries[j + 1] = entries[j];
                        entries[p] = val;
                        n_entries  = n + 1;
                    end
                end
                sle_pkg::MODE_DELETE: begin
                    if (p < 1 || p > n) begin
                        r.status = sle_pkg::STATUS_BADPOS;
                    end else begin
                        for (j = p; j < n; j++)
                            entries[j] = entries[j + 1];
                        n_entries = n - 1;
                    end
                end
                sle_pkg::MODE_LOCATE: begin
                    hit = 1'b0;
                    for (j = 1; j <= n && !hit; j++) begin
                        if (entries[j] == val) begin
                            hit         = 1'b1;
                            r.found_pos = j[sle_pkg::FOUND_W-1:0];
                        end
                    end
                    if (!hit)
                        r.status = sle_pkg::STATUS_NOTFOUND;
                end
                default: begin
                    for (j = 1; j <= n / 2; j++) begin
                        t                  = entries[j];
                        entries[j]         = entries[n - j + 1];
                        entries[n - j + 1] = t;
                    end
                end
            endcase
            r.count = n_entries[sle_pkg::COUNT_W-1:0];
            return r;
        endfunction

        function void note_request(sle_pkg::mode_t md, logic [sle_pkg::POS_W-1:0] pos,
                                   logic [ELEM_W-1:0] val);
            replies_due.push_back(apply_request(md, pos, val));
        endfunction

        function void check_reply(logic [sle_pkg::M_DATA_W-1:0] word);
            reply_t want;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, word);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (word[1:0] !== want.status) begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, word[1:0]);
                errors++;
            end
            if (word[8:2] !== want.found_pos) begin
                $display("%0t: found_position expected %0d actual %0d",
                         $time, want.found_pos, word[8:2]);
                errors++;
            end
            if (word[15:9] !== want.count) begin
                $display("%0t: count expected %0d actual %0d",
                         $time, want.count, word[15:9]);
                errors++;
            end
        endfunction
    endclass

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [S_W-1:0]               s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [sle_pkg::M_DATA_W-1:0] m_tdata;

    bit       quiet_run = 1'b0;
    int       cycles    = 0;
    list_book book      = new();

    sequential_list_engine_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("sequential_list_engine_core test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= quiet_run ? 1'b1 : ($urandom_range(0, 99) >= 12);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready)
            book.check_reply(m_tdata);
    end

    task automatic send_request(input sle_pkg::mode_t md,
                                input logic [sle_pkg::POS_W-1:0] pos,
                                input logic [ELEM_W-1:0] val);
        if (!quiet_run && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tdata  <= {{(S_W - sle_pkg::MODE_W - sle_pkg::POS_W - ELEM_W){1'b0}}, val, pos, md};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        book.note_request(md, pos, val);
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (book.replies_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [ELEM_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return ELEM_W'($urandom_range(0, 7));
        if (roll < 30) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        int                        k;
        int                        n;
        int                        roll;
        int                        hi;
        bit                        grow;
        sle_pkg::mode_t            md;
        logic [sle_pkg::POS_W-1:0] pos;
        logic [ELEM_W-1:0]         val;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(sle_pkg::MODE_LOCATE,  7'd0,   32'h0000_0000);
        send_request(sle_pkg::MODE_DELETE,  7'd1,   32'h0000_0000);
        send_request(sle_pkg::MODE_REVERSE, 7'd0,   32'h0000_0000);
        send_request(sle_pkg::MODE_INSERT,  7'd0,   32'h0000_0005);
        send_request(sle_pkg::MODE_INSERT,  7'd2,   32'h0000_0005);
        send_request(sle_pkg::MODE_INSERT,  7'd1,   32'h8000_0000);
        send_request(sle_pkg::MODE_INSERT,  7'd2,   32'h7fff_ffff);
        send_request(sle_pkg::MODE_INSERT,  7'd1,   32'h0000_0000);
        send_request(sle_pkg::MODE_INSERT,  7'd4,   32'hffff_ffff);
        send_request(sle_pkg::MODE_INSERT,  7'd2,   32'h7fff_ffff);
        send_request(sle_pkg::MODE_LOCATE,  7'd127, 32'h7fff_ffff);
        send_request(sle_pkg::MODE_LOCATE,  7'd0,   32'h8000_0000);
        send_request(sle_pkg::MODE_LOCATE,  7'd0,   32'h0001_2345);
        send_request(sle_pkg::MODE_REVERSE, 7'd127, 32'hffff_ffff);
        send_request(sle_pkg::MODE_DELETE,  7'd0,   32'hffff_ffff);
        send_request(sle_pkg::MODE_DELETE,  7'd6,   32'h0000_0000);
        send_request(sle_pkg::MODE_DELETE,  7'd5,   32'h0000_0000);
        send_request(sle_pkg::MODE_REVERSE, 7'd0,   32'h0000_0000);
        send_request(sle_pkg::MODE_DELETE,  7'd1,   32'h0000_0000);
        send_request(sle_pkg::MODE_INSERT,  7'd127, 32'h5555_aaaa);
        send_request(sle_pkg::MODE_LOCATE,  7'd0,   32'hffff_ffff);
        send_request(sle_pkg::MODE_DELETE,  7'd2,   32'h0000_0000);
        send_request(sle_pkg::MODE_LOCATE,  7'd0,   32'hffff_ffff);

        grow = 1'b1;
        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k == 300)
                quiet_run <= 1'b1;
            if (k == 450)
                quiet_run <= 1'b0;
            if (k == 600)
                drain_replies();

            n = book.n_entries;
            if (grow && n >= LIST_DEPTH - 1 && $urandom_range(0, 9) == 0)
                grow = 1'b0;
            else if (!grow && n == 0 && $urandom_range(0, 3) == 0)
                grow = 1'b1;

            roll = $urandom_range(0, 99);
            if (grow)
                md = roll < 75 ? sle_pkg::MODE_INSERT : roll < 80 ? sle_pkg::MODE_DELETE :
                     roll < 92 ? sle_pkg::MODE_LOCATE : sle_pkg::MODE_REVERSE;
            else
                md = roll < 12 ? sle_pkg::MODE_INSERT : roll < 80 ? sle_pkg::MODE_DELETE :
                     roll < 92 ? sle_pkg::MODE_LOCATE : sle_pkg::MODE_REVERSE;

            pos = sle_pkg::POS_W'($urandom_range(0, 127));
            val = pick_value();
            case (md)
                sle_pkg::MODE_INSERT: begin
                    hi = (n + 1 > 127) ? 127 : n + 1;
                    if ($urandom_range(0, 9) != 0)
                        pos = sle_pkg::POS_W'($urandom_range(1, hi));
                end
                sle_pkg::MODE_DELETE: begin
                    if (n > 0 && $urandom_range(0, 9) != 0)
                        pos = sle_pkg::POS_W'($urandom_range(1, n));
                end
                sle_pkg::MODE_LOCATE: begin
                    if (n > 0 && $urandom_range(0, 9) < 7)
                        val = book.entries[$urandom_range(1, n)];
                end
                default: begin
                end
            endcase
            send_request(md, pos, val);
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (book.errors == 0 && book.replies_due.size() == 0) begin
            $display("sequential_list_engine_core test passed");
        end else begin
            $display("sequential_list_engine_core test failed");
        end
        $finish;
    end

endmodule
